// File: src/matrix_keypad_scanner_fifo_macros.svh
// assertion macros for the keypad scanner checker
// expects clk and rst in scope where used
`ifndef MATRIX_KEYPAD_SCANNER_FIFO_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_FIFO_MACROS_SVH

// same-cycle implication
`define MKSF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MKSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mksf_pkg.sv
// shared types, constants and key encoder for the keypad scanner
// no dependencies
package mksf_pkg;

  localparam int FIFO_DEPTH_DEF = 16;
  localparam int KEY_W = 8;
  localparam int LEVELS_W = 16;
  localparam int TIME_W = 32;
  localparam int REFR_W = 20;
  localparam int COUNT_W = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [REFR_W-1:0] REFRACTORY_RESET_US = 20'd30000;
  localparam logic [PADDR_W-3:0] REG_REFRACTORY = '0;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    CMD_SHOW,
    CMD_PUSH,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [KEY_W-1:0] code;
  } cmd_t;

  // rows "123a", "456b", "789c", "s0pd"
  localparam logic [KEY_W-1:0] KEY_MAP [LEVELS_W] = '{
    8'h31, 8'h32, 8'h33, 8'h61,
    8'h34, 8'h35, 8'h36, 8'h62,
    8'h37, 8'h38, 8'h39, 8'h63,
    8'h73, 8'h30, 8'h70, 8'h64
  };

  // first low bit wins, zero when none is low
  function automatic logic [KEY_W-1:0] key_encode(input logic [LEVELS_W-1:0] levels);
    logic [KEY_W-1:0] code;
    code = '0;
    for (int i = LEVELS_W - 1; i >= 0; i--) begin
      if (!levels[i]) begin
        code = KEY_MAP[i];
      end
    end
    return code;
  endfunction

endpackage

// File: src/mksf_if.sv
// valid/ready channel interfaces for scan items and results
// depends on mksf_pkg
interface mksf_in_if;
  import mksf_pkg::*;
  logic valid;
  logic ready;
  logic operation;
  logic [LEVELS_W-1:0] column_levels;
  logic [TIME_W-1:0] now_us;
  modport source(output valid, operation, column_levels, now_us, input ready);
  modport sink(input valid, operation, column_levels, now_us, output ready);
endinterface

interface mksf_out_if;
  import mksf_pkg::*;
  logic valid;
  logic ready;
  logic [KEY_W-1:0] key_code;
  logic key_queued;
  logic key_dropped;
  logic [COUNT_W-1:0] fifo_count;
  modport source(output valid, key_code, key_queued, key_dropped, fifo_count, input ready);
  modport sink(input valid, key_code, key_queued, key_dropped, fifo_count, output ready);
endinterface

// File: src/matrix_keypad_scanner_fifo.sv
// Keypad scanner with key queue. One item (scan or read) is accepted per clock while the command
// queue has room; one result comes out per item, after the item passes the command queue and the
// result register. The sustained rate is one item per cycle while the output is not stalled, set
// by the key fifo access in the back end. A two-entry command queue lets the input take up to two
// more items while a result waits. The refractory register must be written over the APB port only
// while the block is idle, not enforced by the block; the key fifo needs no clearing after reset.
// depends on mksf_pkg, mksf_if, mksf_front, mksf_cmd_q, mksf_back
module matrix_keypad_scanner_fifo #(
  parameter int FIFO_DEPTH = mksf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  mksf_in_if.sink                       in_ch,
  mksf_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mksf_pkg::PADDR_W-1:0]  paddr,
  input  logic [mksf_pkg::PDATA_W-1:0]  pwdata,
  output logic [mksf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import mksf_pkg::*;

  logic [REFR_W-1:0] refractory_us;
  logic reg_hit;

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic b_valid;
  logic b_ready;
  cmd_t b_cmd;

  assign pready = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_REFRACTORY);
  assign prdata = reg_hit ? {{(PDATA_W-REFR_W){1'b0}}, refractory_us} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      refractory_us <= REFRACTORY_RESET_US;
    end else if (psel && penable && pwrite && reg_hit) begin
      refractory_us <= pwdata[REFR_W-1:0];
    end
  end

  mksf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .refractory_us (refractory_us),
    .q_ready       (f_ready),
    .q_valid       (f_valid),
    .q_cmd         (f_cmd)
  );

  mksf_cmd_q u_cmd_q (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_cmd   (f_cmd),
    .push_ready (f_ready),
    .pop_valid  (b_valid),
    .pop_cmd    (b_cmd),
    .pop_ready  (b_ready)
  );

  mksf_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd       (b_cmd),
    .cmd_ready (b_ready),
    .out_ch    (out_ch)
  );

endmodule

// File: src/mksf_front.sv
// front end: accepts items, encodes the key and qualifies presses
// depends on mksf_pkg and mksf_in_if
module mksf_front (
  input  logic                         clk,
  input  logic                         rst,
  mksf_in_if.sink                      in_ch,
  input  logic [mksf_pkg::REFR_W-1:0]  refractory_us,
  input  logic                         q_ready,
  output logic                         q_valid,
  output mksf_pkg::cmd_t               q_cmd
);
  import mksf_pkg::*;

  logic [KEY_W-1:0] prev_key;
  logic [TIME_W-1:0] allowed_after_us;
  logic [KEY_W-1:0] code;
  logic [TIME_W-1:0] diff;
  logic changed;
  logic accept;

  assign in_ch.ready = q_ready;
  assign q_valid = in_ch.valid;
  assign accept = in_ch.valid && q_ready;

  assign code = key_encode(in_ch.column_levels);
  assign changed = (code != prev_key);
  assign diff = in_ch.now_us - allowed_after_us;

  always_comb begin
    q_cmd.code = code;
    if (in_ch.operation == OP_READ) begin
      q_cmd.kind = CMD_READ;
    end else if (changed && (code != '0) && !diff[TIME_W-1]) begin
      q_cmd.kind = CMD_PUSH;
    end else begin
      q_cmd.kind = CMD_SHOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_key <= '0;
      allowed_after_us <= '0;
    end else if (accept && (in_ch.operation == OP_SCAN) && changed) begin
      prev_key <= code;
      // release opens the refractory window
      if (code == '0) begin
        allowed_after_us <= in_ch.now_us + {{(TIME_W-REFR_W){1'b0}}, refractory_us};
      end
    end
  end

endmodule

// File: src/mksf_cmd_q.sv
// two-entry command queue between front and back
// depends on mksf_pkg
module mksf_cmd_q (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  mksf_pkg::cmd_t  push_cmd,
  output logic            push_ready,
  output logic            pop_valid,
  output mksf_pkg::cmd_t  pop_cmd,
  input  logic            pop_ready
);
  import mksf_pkg::*;

  cmd_t ent [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_cmd = ent[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: src/mksf_back.sv
// back end: key fifo storage, pops and pushes, result register
// depends on mksf_pkg and mksf_out_if
module mksf_back #(
  parameter int FIFO_DEPTH = mksf_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  mksf_pkg::cmd_t  cmd,
  output logic            cmd_ready,
  mksf_out_if.source      out_ch
);
  import mksf_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [KEY_W-1:0] mem [FIFO_DEPTH];
  logic [KEY_W-1:0] mem_rdata;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic [CW+COUNT_W-1:0] fill_ext;

  logic res_valid;
  logic [KEY_W-1:0] res_code;
  logic res_queued;
  logic res_dropped;
  logic [COUNT_W-1:0] res_count;
  logic res_from_mem;

  logic consume;
  logic do_push;
  logic do_pop;
  logic is_full;

  assign cmd_ready = !res_valid || out_ch.ready;
  assign consume = cmd_valid && cmd_ready;
  assign is_full = (fill == CW'(FIFO_DEPTH));
  assign do_push = consume && (cmd.kind == CMD_PUSH) && !is_full;
  assign do_pop = consume && (cmd.kind == CMD_READ) && (fill != '0);

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   fill_next = fill + CW'(1);
      2'b01:   fill_next = fill - CW'(1);
      default: fill_next = fill;
    endcase
  end

  assign fill_ext = {{COUNT_W{1'b0}}, fill_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
      res_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      if (do_pop) begin
        head <= (head == AW'(FIFO_DEPTH - 1)) ? '0 : head + AW'(1);
      end
      if (do_push) begin
        tail <= (tail == AW'(FIFO_DEPTH - 1)) ? '0 : tail + AW'(1);
      end
      if (consume) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      res_code <= (cmd.kind == CMD_READ) ? '0 : cmd.code;
      res_queued <= do_push;
      res_dropped <= consume && (cmd.kind == CMD_PUSH) && is_full;
      res_count <= fill_ext[COUNT_W-1:0];
      res_from_mem <= do_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= cmd.code;
    end
    if (do_pop) begin
      mem_rdata <= mem[head];
    end
  end

  assign out_ch.valid = res_valid;
  assign out_ch.key_code = res_from_mem ? mem_rdata : res_code;
  assign out_ch.key_queued = res_queued;
  assign out_ch.key_dropped = res_dropped;
  assign out_ch.fifo_count = res_count;

endmodule

// File: src/mksf_checker.sv
// port-level checks on the keypad scanner results, bound to the top level
// depends on matrix_keypad_scanner_fifo_macros.svh
`include "matrix_keypad_scanner_fifo_macros.svh"

module mksf_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] key_code,
  input logic       key_queued,
  input logic       key_dropped,
  input logic [4:0] fifo_count
);

  `MKSF_ASSERT_IMPL(a_flags_excl, out_valid, !(key_queued && key_dropped), "queued and dropped together")
  `MKSF_ASSERT_IMPL(a_queued_key, out_valid && key_queued, key_code != 8'd0, "queued a null key")
  `MKSF_ASSERT_IMPL(a_dropped_key, out_valid && key_dropped, key_code != 8'd0, "dropped a null key")
  `MKSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({key_code, key_queued, key_dropped, fifo_count}), "stalled result changed")

endmodule

bind matrix_keypad_scanner_fifo mksf_checker u_mksf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .key_code    (out_ch.key_code),
  .key_queued  (out_ch.key_queued),
  .key_dropped (out_ch.key_dropped),
  .fifo_count  (out_ch.fifo_count)
);
